@@ rtl/selective_repeat_sender_window_top_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the selective-repeat sender window checker
// ---------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_TOP_MACROS_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_TOP_MACROS_SVH

// Check a property on every edge outside reset
`define SRSW_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("srsw check failed");

// Check a property on every edge, reset included
`define SRSW_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("srsw reset check failed");

`endif

@@ rtl/srsw_pkg.sv @@
// ---------------------------------------------------------------------------
// srsw_pkg
// Types and constants shared by the selective-repeat sender window modules.
// ---------------------------------------------------------------------------
`default_nettype none

package srsw_pkg;

  localparam int SEQ_SPACE    = 8;
  localparam int SEQ_W        = $clog2(SEQ_SPACE);
  localparam int PAYLOAD_BITS = 32;
  localparam int WIN_W        = 3;
  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(4);

  // Request opcodes
  localparam logic [1:0] OP_SEND    = 2'd0;
  localparam logic [1:0] OP_ACK     = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [SEQ_W-1:0]        sequence_number;
    logic                    checksum_ok;
  } in_item_t;

  typedef struct packed {
    logic                    accepted;
    logic                    send_valid;
    logic [SEQ_W-1:0]        send_sequence;
    logic [PAYLOAD_BITS-1:0] send_payload;
    logic                    timer_start;
    logic                    timer_stop;
    logic [SEQ_W-1:0]        timer_sequence;
    logic [SEQ_W-1:0]        window_base;
    logic                    window_full;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
  } srsw_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } srsw_state_t;

endpackage

`default_nettype wire

@@ rtl/srsw_ctrl.sv @@
// ---------------------------------------------------------------------------
// srsw_ctrl
// Sequencer: takes a request, runs it through the datapath, owns out_valid.
// ---------------------------------------------------------------------------
`default_nettype none

module srsw_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output srsw_pkg::srsw_cmd_t    cmd
);

  srsw_pkg::srsw_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  exec_go;

  assign in_ready  = (state_r == srsw_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  // Execute once the output register is free or being drained
  assign exec_go = (state_r == srsw_pkg::ST_EXEC) && (!out_valid_r || out_ready);

  assign cmd.capture = in_valid && in_ready;
  assign cmd.exec    = exec_go;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srsw_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = srsw_pkg::ST_EXEC;
      end
      srsw_pkg::ST_EXEC: begin
        if (exec_go) state_nxt = srsw_pkg::ST_IDLE;
      end
      default: state_nxt = srsw_pkg::ST_IDLE;
    endcase
  end

  // Load on execute, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_go) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srsw_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/srsw_dp.sv @@
// ---------------------------------------------------------------------------
// srsw_dp
// Window datapath: pointers, ack marks, packet store, slide scan, result.
// ---------------------------------------------------------------------------
`default_nettype none

module srsw_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire srsw_pkg::srsw_cmd_t                cmd,
  input  wire srsw_pkg::in_item_t                 in_data,
  input  wire logic                               cfg_wr_en,
  input  wire logic [srsw_pkg::WIN_W-1:0]         cfg_wr_data,
  output srsw_pkg::out_item_t                     out_data
);

  localparam int SW = srsw_pkg::SEQ_W;
  localparam int N  = srsw_pkg::SEQ_SPACE;

  logic [srsw_pkg::WIN_W-1:0]        ws_r;
  logic [SW-1:0]                     base_r, base_nxt;
  logic [SW-1:0]                     next_r, next_nxt;
  logic [N-1:0]                      marks_r, marks_nxt;
  logic [srsw_pkg::PAYLOAD_BITS-1:0] store_mem [N];
  logic [srsw_pkg::PAYLOAD_BITS-1:0] rd_r;
  srsw_pkg::in_item_t                item_r;
  srsw_pkg::out_item_t               out_r, res;
  logic                              store_we;

  logic [SW-1:0]  dist_next, dist_seq, dist_j;
  logic           full_now;
  logic [N-1:0]   marks_set;
  logic [SW-1:0]  slide_k;
  logic           run;
  logic [SW-1:0]  idx;

  assign out_data = out_r;

  // Offsets from the base wrap naturally over the sequence space
  assign dist_next = next_r - base_r;
  assign dist_seq  = item_r.sequence_number - base_r;
  assign full_now  = ({{(srsw_pkg::WIN_W > SW ? srsw_pkg::WIN_W - SW : 0){1'b0}}, dist_next}
                      >= ws_r);

  // Slide scan: count contiguous acked slots from the base, up to window size
  always_comb begin
    marks_set = marks_r | (N'(1) << item_r.sequence_number);
    slide_k   = '0;
    run       = 1'b1;
    idx       = '0;
    for (int i = 0; i < N; i++) begin
      idx = base_r + SW'(i);
      if (run && (srsw_pkg::WIN_W'(i) < ws_r) && marks_set[idx]) slide_k = slide_k + 1'b1;
      else run = 1'b0;
    end
  end

  // Work out the result and the next window state
  always_comb begin
    res        = '0;
    base_nxt   = base_r;
    next_nxt   = next_r;
    marks_nxt  = marks_r;
    store_we   = 1'b0;
    dist_j     = '0;
    case (item_r.opcode)
      srsw_pkg::OP_SEND: begin
        if (!full_now) begin
          store_we           = 1'b1;
          res.accepted       = 1'b1;
          res.send_valid     = 1'b1;
          res.send_sequence  = next_r;
          res.send_payload   = item_r.payload;
          res.timer_start    = 1'b1;
          res.timer_sequence = next_r;
          next_nxt           = next_r + 1'b1;
        end
      end
      srsw_pkg::OP_ACK: begin
        if (item_r.checksum_ok && ({1'b0, dist_seq} < {1'b0, ws_r})) begin
          for (int j = 0; j < N; j++) begin
            dist_j       = SW'(j) - base_r;
            marks_nxt[j] = marks_set[j] && !(dist_j < slide_k);
          end
          base_nxt           = base_r + slide_k;
          res.accepted       = 1'b1;
          res.timer_stop     = 1'b1;
          res.timer_sequence = item_r.sequence_number;
        end
      end
      srsw_pkg::OP_TIMEOUT: begin
        res.timer_start    = 1'b1;
        res.timer_sequence = item_r.sequence_number;
        if (dist_seq < dist_next) begin
          res.send_valid    = 1'b1;
          res.send_sequence = item_r.sequence_number;
          res.send_payload  = rd_r;
        end
      end
      default: begin
      end
    endcase
    res.window_base = base_nxt;
    res.window_full = ({1'b0, SW'(next_nxt - base_nxt)} >= {1'b0, ws_r});
  end

  // Control state: pointers, marks, window size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r    <= srsw_pkg::WINDOW_RESET;
      base_r  <= '0;
      next_r  <= '0;
      marks_r <= '0;
    end else begin
      if (cfg_wr_en) ws_r <= cfg_wr_data;
      if (cmd.exec) begin
        base_r  <= base_nxt;
        next_r  <= next_nxt;
        marks_r <= marks_nxt;
      end
    end
  end

  // Hold the request and read its store entry on capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
      rd_r   <= store_mem[in_data.sequence_number];
    end
  end

  // Store the payload of a taken send
  always_ff @(posedge clk) begin
    if (cmd.exec && store_we) store_mem[next_r] <= item_r.payload;
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (cmd.exec) out_r <= res;
  end

endmodule

`default_nettype wire

@@ rtl/selective_repeat_sender_window_top.sv @@
// ---------------------------------------------------------------------------
// selective_repeat_sender_window_top
// Selective-repeat ARQ sender window with one result per request.
// ---------------------------------------------------------------------------
//  channel  | ports                          | moves
//  ---------+--------------------------------+----------------------------
//  in       | in_valid, in_ready, in_data    | send / ack / timeout request
//  out      | out_valid, out_ready, out_data | one result per request
//  cfg      | cfg_wr_en, cfg_wr_data         | window_size write
//
//  In the accept cycle a request reads the packet store; the execute state
//  then runs the slide scan over the ack marks and loads the output
//  register. The next request is accepted the cycle after that.
//  A stalled result holds the block in its execute cycle until taken.
//  Reset clears pointers and ack marks at once; window_size returns to 4.
// ---------------------------------------------------------------------------
`default_nettype none

module selective_repeat_sender_window_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire srsw_pkg::in_item_t         in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output srsw_pkg::out_item_t             out_data,
  input  wire logic                       cfg_wr_en,
  input  wire logic [srsw_pkg::WIN_W-1:0] cfg_wr_data
);

  srsw_pkg::srsw_cmd_t cmd;

  // Sequencer
  srsw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Window datapath
  srsw_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

@@ rtl/srsw_checker.sv @@
// ---------------------------------------------------------------------------
// srsw_checker
// Port-level checks on the sender window, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "selective_repeat_sender_window_top_macros.svh"

module srsw_checker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic                       in_ready,
  input  wire logic                       out_valid,
  input  wire logic                       out_ready,
  input  wire srsw_pkg::out_item_t        out_data
);

  logic stop_ok;
  logic start_ok;

  // A stop comes only with an accepted ack that emits nothing
  assign stop_ok  = out_data.accepted && !out_data.timer_start && !out_data.send_valid;
  // A taken send names its own timer
  assign start_ok = out_data.timer_start &&
                    (out_data.timer_sequence == out_data.send_sequence);

  // Hold a stalled result
  `SRSW_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))

  // Stop a timer only for an accepted ack
  `SRSW_ASSERT(a_stop_accepted, (out_valid && out_data.timer_stop) |-> stop_ok)

  // A taken send starts the timer of the packet it emits
  `SRSW_ASSERT(a_send_timer, (out_valid && out_data.accepted && out_data.send_valid) |-> start_ok)

  // Take one request at a time
  `SRSW_ASSERT(a_single_request, (in_valid && in_ready) |=> !in_ready)

  // Drop any result across reset
  `SRSW_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid)

endmodule

bind selective_repeat_sender_window_top srsw_checker u_srsw_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_data    (out_data)
);

`default_nettype wire

@@ bench/srsw_window_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srsw_window_checker
// Watches the request, result and window-size ports of the sender window,
// tracks the window on its own and compares every result with the oldest
// prediction. It also exposes the tracked pointers so that the stimulus can
// aim acks and timeouts at packets in flight.
// ---------------------------------------------------------------------------
module srsw_window_checker
  import srsw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_item_t            out_data,
  input  logic                 cfg_wr_en,
  input  logic [WIN_W-1:0]     cfg_wr_data,
  output int                   fail_count,
  output int                   pending,
  output logic [SEQ_W-1:0]     base_seq,
  output logic [SEQ_W-1:0]     next_seq,
  output logic [SEQ_SPACE-1:0] store_written
);

  logic [WIN_W-1:0]        size_limit;
  logic                    ack_mark [SEQ_SPACE];
  logic [PAYLOAD_BITS-1:0] payload_store [SEQ_SPACE];
  out_item_t               expected_results [$];

  // Slots between the base and the next number are in flight
  function automatic logic window_is_full();
    return SEQ_W'(next_seq - base_seq) >= size_limit;
  endfunction

  // Apply one request to the tracked window and return its result
  function automatic out_item_t window_step(in_item_t req);
    out_item_t        res;
    logic [SEQ_W-1:0] s;
    int               i;
    res = '0;
    s = req.sequence_number;
    case (req.opcode)
      OP_SEND: begin
        if (!window_is_full()) begin
          payload_store[next_seq] = req.payload;
          store_written[next_seq] = 1'b1;
          res.accepted       = 1'b1;
          res.send_valid     = 1'b1;
          res.send_sequence  = next_seq;
          res.send_payload   = req.payload;
          res.timer_start    = 1'b1;
          res.timer_sequence = next_seq;
          next_seq = next_seq + 1'b1;
        end
      end
      OP_ACK: begin
        if (req.checksum_ok && SEQ_W'(s - base_seq) < size_limit) begin
          ack_mark[s] = 1'b1;
          // slide past contiguous acked slots, at most one window
          for (i = 0; i < int'(size_limit) && ack_mark[base_seq]; i++) begin
            ack_mark[base_seq] = 1'b0;
            base_seq = base_seq + 1'b1;
          end
          res.accepted       = 1'b1;
          res.timer_stop     = 1'b1;
          res.timer_sequence = s;
        end
      end
      OP_TIMEOUT: begin
        res.timer_start    = 1'b1;
        res.timer_sequence = s;
        // re-emit only a packet still in flight
        if (SEQ_W'(s - base_seq) < SEQ_W'(next_seq - base_seq)) begin
          res.send_valid    = 1'b1;
          res.send_sequence = s;
          res.send_payload  = payload_store[s];
        end
      end
      default: ;
    endcase
    res.window_base = base_seq;
    res.window_full = window_is_full();
    return res;
  endfunction

  task automatic check_field(string name, logic [PAYLOAD_BITS-1:0] want,
                             logic [PAYLOAD_BITS-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h",
               $time, name, want, got);
      fail_count++;
    end
  endtask

  // Pop and compare results first, then predict the accepted request
  always @(posedge clk) begin : track
    out_item_t want;
    if (!rst_n) begin
      size_limit    = WINDOW_RESET;
      base_seq      = '0;
      next_seq      = '0;
      store_written = '0;
      fail_count    = 0;
      foreach (ack_mark[k]) ack_mark[k] = 1'b0;
      foreach (payload_store[k]) payload_store[k] = '0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: result with no request waiting, expected none, actual %p",
                   $time, out_data);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("accepted", want.accepted, out_data.accepted);
          check_field("send_valid", want.send_valid, out_data.send_valid);
          check_field("send_sequence", want.send_sequence, out_data.send_sequence);
          check_field("send_payload", want.send_payload, out_data.send_payload);
          check_field("timer_start", want.timer_start, out_data.timer_start);
          check_field("timer_stop", want.timer_stop, out_data.timer_stop);
          check_field("timer_sequence", want.timer_sequence, out_data.timer_sequence);
          check_field("window_base", want.window_base, out_data.window_base);
          check_field("window_full", want.window_full, out_data.window_full);
        end
      end
      if (in_valid && in_ready)
        expected_results = {expected_results, window_step(in_data)};
      if (cfg_wr_en)
        size_limit = cfg_wr_data;
    end
    pending = expected_results.size();
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Regression for the selective-repeat sender window: a directed pass over
// sends, acks and timeouts at the window edges, then random phases at
// several window sizes and idle patterns, checked by the window checker.
// ---------------------------------------------------------------------------
module tb_top;
  import srsw_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int         PHASES    = 8;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_wr_en;
  logic [WIN_W-1:0]     cfg_wr_data;
  int                   fail_count;
  int                   pending;
  logic [SEQ_W-1:0]     win_base;
  logic [SEQ_W-1:0]     win_next;
  logic [SEQ_SPACE-1:0] store_written;
  int                   gap_pct   = 0;
  int                   stall_pct = 0;

  selective_repeat_sender_window_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  srsw_window_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .base_seq     (win_base),
    .next_seq     (win_next),
    .store_written(store_written)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stall the result channel at the current rate
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("selective_repeat_sender_window_top regression: fail");
    $finish;
  end

  function automatic in_item_t make_req(logic [1:0] op, logic [PAYLOAD_BITS-1:0] pay,
                                        logic [SEQ_W-1:0] seq, logic ok);
    in_item_t req;
    req.opcode          = op;
    req.payload         = pay;
    req.sequence_number = seq;
    req.checksum_ok     = ok;
    return req;
  endfunction

  // Called at a falling edge; returns at a falling edge with valid still high
  task automatic issue_request(in_item_t req);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Let the pending results drain, then write a new window size
  task automatic set_window(logic [WIN_W-1:0] size);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= size;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    in_item_t         req;
    logic [WIN_W-1:0] size;
    logic [SEQ_W-1:0] pick;
    int               n_out;
    int               r;
    int               count;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed pass at the reset window of four
    issue_request(make_req(OP_TIMEOUT, 32'h0, 3'd5, 1'b0));       // nothing in flight
    issue_request(make_req(OP_UNUSED, '1, 3'd7, 1'b1));
    issue_request(make_req(OP_SEND, 32'h0000_0000, 3'd7, 1'b1));
    issue_request(make_req(OP_SEND, 32'hFFFF_FFFF, 3'd0, 1'b0));
    issue_request(make_req(OP_SEND, 32'hA5A5_A5A5, 3'd2, 1'b1));
    issue_request(make_req(OP_SEND, 32'h5A5A_5A5A, 3'd5, 1'b0));
    issue_request(make_req(OP_SEND, 32'h1234_5678, 3'd0, 1'b1));  // window full
    issue_request(make_req(OP_ACK, '0, 3'd2, 1'b0));              // bad checksum
    issue_request(make_req(OP_ACK, '0, 3'd5, 1'b1));              // beyond the window
    issue_request(make_req(OP_ACK, '1, 3'd1, 1'b1));              // out of order
    issue_request(make_req(OP_TIMEOUT, '0, 3'd1, 1'b1));          // acked, not slid yet
    issue_request(make_req(OP_TIMEOUT, '0, 3'd3, 1'b0));
    issue_request(make_req(OP_ACK, '0, 3'd0, 1'b1));              // slide two
    issue_request(make_req(OP_SEND, 32'h8000_0001, 3'd0, 1'b0));
    issue_request(make_req(OP_SEND, 32'h7FFF_FFFE, 3'd0, 1'b0));
    for (int s = 2; s < 6; s++)
      issue_request(make_req(OP_ACK, $urandom, SEQ_W'(s), 1'b1));
    issue_request(make_req(OP_SEND, 32'hDEAD_0006, 3'd3, 1'b0));
    issue_request(make_req(OP_SEND, 32'hBEEF_0007, 3'd4, 1'b1));
    issue_request(make_req(OP_ACK, '0, 3'd7, 1'b1));
    issue_request(make_req(OP_ACK, '0, 3'd6, 1'b1));              // wrap the base
    issue_request(make_req(OP_ACK, '0, 3'd0, 1'b1));              // number not sent since the wrap
    issue_request(make_req(OP_TIMEOUT, '0, 3'd4, 1'b1));

    // Random phases over window sizes and idle patterns
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: size = 3'd1;
        1: size = 3'd7;
        2: size = 3'd4;
        3: size = 3'd0;
        4: size = 3'd2;
        5: size = 3'd5;
        6: size = 3'd3;
        default: size = 3'd6;
      endcase
      set_window(size);
      case (phase % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 83; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 83; end
        default: begin gap_pct = 27; stall_pct = 27; end
      endcase
      count = (size == 0) ? 20 : 70;
      repeat (count) begin
        n_out = int'(SEQ_W'(win_next - win_base));
        pick  = win_base + SEQ_W'($urandom_range(n_out == 0 ? 0 : n_out - 1));
        req.payload         = $urandom;
        req.sequence_number = SEQ_W'($urandom);
        req.checksum_ok     = $urandom_range(1);
        if ($urandom_range(15) == 0)
          req.payload = $urandom_range(1) ? '1 : '0;
        r = $urandom_range(99);
        if (r < 40) begin
          req.opcode = OP_SEND;
        end else if (r < 70) begin
          // mostly acks for packets in flight, the rest noise
          req.opcode = OP_ACK;
          if (n_out > 0 && $urandom_range(9) != 0) begin
            req.sequence_number = pick;
            req.checksum_ok     = 1'b1;
          end
        end else if (r < 88) begin
          req.opcode = OP_TIMEOUT;
          if (n_out > 0)
            req.sequence_number = pick;
        end else begin
          req.opcode = 2'($urandom_range(3));
        end
        // never re-emit a slot that was never filled
        if (req.opcode == OP_TIMEOUT && !store_written[req.sequence_number] &&
            SEQ_W'(req.sequence_number - win_base) < SEQ_W'(win_next - win_base))
          req.sequence_number = win_next;
        issue_request(req);
      end
    end

    // Drain and settle
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("selective_repeat_sender_window_top regression: pass");
    else
      $display("selective_repeat_sender_window_top regression: fail");
    $finish;
  end

endmodule
